/* design/bsr_pkg.sv */
// Shared sizes and the per-cell state type for the bisection square root.
`default_nettype none
package bsr_pkg;

   localparam int INPUT_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ROOT_BITS  = (INPUT_BITS + 1) / 2 + FRAC_BITS;
   localparam int RAD_BITS   = 2 * ((INPUT_BITS + 1) / 2);
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int PORT_BITS  = 32;

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } stage_type;

endpackage
`default_nettype wire

/* design/bsr_if.sv */
// Valid/ready channel interfaces for radicand requests and root responses.
`default_nettype none
interface bsr_req_if;
   logic                           valid;
   logic                           ready;
   logic [bsr_pkg::PORT_BITS-1:0]  radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

interface bsr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsr_pkg::PORT_BITS-1:0]  root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface
`default_nettype wire

/* design/bisection_square_root.sv */
// Top level: a chain of cells computing a Q16.16 root of a 32-bit radicand.
//
//   Channel   Direction   Payload              Meaning
//   req_ch    in          radicand[31:0]       unsigned integer radicand
//   rsp_ch    out         root[31:0]           sqrt(radicand) truncated to Q16.16
//
// Each transaction walks through 32 cells (one per root bit), each of which
// registers it in turn; the root is offered from the last cell's register.
// A cell takes a new transaction whenever it is empty or its neighbor takes its
// contents, so up to 32 transactions are in flight and, while the response is
// not stalled, one may enter per cycle. A stalled response holds the last cell;
// the stall reaches the request side only once every cell is occupied.
// Reset clears the valid bit of every cell; no other clearing is done.
`default_nettype none
module bisection_square_root (
   input  wire logic  clock,
   input  wire logic  reset,
   bsr_req_if.sink    req_ch,
   bsr_rsp_if.source  rsp_ch
);

   logic               link_valid [bsr_pkg::ROOT_BITS+1];
   logic               link_ready [bsr_pkg::ROOT_BITS+1];
   bsr_pkg::stage_type link_data  [bsr_pkg::ROOT_BITS+1];

   assign link_valid[0]     = req_ch.valid;
   assign req_ch.ready      = link_ready[0];
   assign link_data[0].rad  = bsr_pkg::RAD_BITS'(req_ch.radicand[bsr_pkg::INPUT_BITS-1:0]);
   assign link_data[0].rem  = '0;
   assign link_data[0].root = '0;

   for (genvar i = 0; i < bsr_pkg::ROOT_BITS; i++) begin : g_cell
      bsr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   assign rsp_ch.valid                   = link_valid[bsr_pkg::ROOT_BITS];
   assign link_ready[bsr_pkg::ROOT_BITS] = rsp_ch.ready;
   assign rsp_ch.root = bsr_pkg::PORT_BITS'(link_data[bsr_pkg::ROOT_BITS].root);

endmodule
`default_nettype wire

/* design/bsr_cell.sv */
// One cell of the root chain: decides one root bit and holds its transaction.
`default_nettype none
module bsr_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bsr_pkg::stage_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bsr_pkg::stage_type      out_data
);

   logic                              valid_ff;
   logic                              valid_in;
   bsr_pkg::stage_type                data_ff;
   bsr_pkg::stage_type                data_in;
   bsr_pkg::stage_type                step;
   logic [bsr_pkg::REM_BITS-1:0]      partial;
   logic [bsr_pkg::REM_BITS-1:0]      test;
   logic                              take;

   // The remainder never exceeds twice the partial root, so its top two bits are free.
   always_comb begin
      partial   = {in_data.rem[bsr_pkg::REM_BITS-3:0], in_data.rad[bsr_pkg::RAD_BITS-1 -: 2]};
      test      = {in_data.root, 2'b01};
      take      = (partial >= test);
      step.rad  = {in_data.rad[bsr_pkg::RAD_BITS-3:0], 2'b00};
      step.rem  = take ? (partial - test) : partial;
      step.root = {in_data.root[bsr_pkg::ROOT_BITS-2:0], take};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         data_in  = step;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

`ifndef NO_ASSERTIONS
   a_take_fills : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("Accepted transaction did not occupy the cell.");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, data_ff.rem} <= {2'b00, data_ff.root, 1'b0}))
      else $error("Remainder exceeds twice the partial root.");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("Stalled cell changed its contents.");
`endif

endmodule
`default_nettype wire
